FILE: rtl/core/amp_pkg.sv
// shared constants, types and state codes for the aliased memory placer
package amp_pkg;

   localparam int MAX_RES    = 64;
   localparam int SLOT_W     = 6;
   localparam int SLOT_CNT_W = 7;
   localparam int SIZE_W     = 40;
   localparam int WT_W       = 16;
   localparam int POS_W      = 47;
   localparam int BYTE_W     = 56;
   localparam int BLK_W      = 17;
   localparam int PROD_W     = 64;
   localparam int STEP_W     = 6;

   localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(MAX_RES - 1);
   localparam logic [SLOT_CNT_W-1:0] SLOT_CNT  = SLOT_CNT_W'(MAX_RES);
   localparam logic [BYTE_W-1:0]     BYTE_MAX  = {BYTE_W{1'b1}};

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEL_RD,
      ST_SEL_EX,
      ST_EMIT,
      ST_CUR_RD,
      ST_CUR_EX,
      ST_DIVW,
      ST_A_RD,
      ST_A_EX,
      ST_K_RD,
      ST_K_EX,
      ST_J_RD,
      ST_J_EX,
      ST_FIN,
      ST_MULW,
      ST_POOL,
      ST_POOLW,
      ST_LASTOUT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_mul;
   } md_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage

FILE: rtl/core/amp_if.sv
// handshake channel interfaces for the placer
interface amp_req_if;
   logic                            valid;
   logic                            ready;
   logic                            op;
   logic [amp_pkg::SLOT_W-1:0]      resource_id;
   logic [amp_pkg::SIZE_W-1:0]      size_bytes;
   logic [amp_pkg::WT_W-1:0]        rank_weight;
   logic [amp_pkg::MAX_RES-1:0]     conflict_mask;
   modport source (output valid, op, resource_id, size_bytes, rank_weight, conflict_mask,
                   input ready);
   modport sink (input valid, op, resource_id, size_bytes, rank_weight, conflict_mask,
                 output ready);
endinterface

interface amp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [amp_pkg::SLOT_W-1:0]      placed_id;
   logic [amp_pkg::BYTE_W-1:0]      offset_bytes;
   logic [amp_pkg::BYTE_W-1:0]      pool_bytes;
   logic                            last;
   modport source (output valid, placed_id, offset_bytes, pool_bytes, last, input ready);
   modport sink (input valid, placed_id, offset_bytes, pool_bytes, last, output ready);
endinterface

interface amp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [amp_pkg::BLK_W-1:0]       data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/aliased_memory_best_fit_placer.sv
// top level of the aliased memory best-fit placer: sequencer and placement datapath
//
// channels: req_bus takes load items (op 0) that write one slot's size, weight and
// conflict row, and start items (op 1) that place every loaded slot. rsp_bus gives one
// transfer per placed slot in size order (largest first, then higher weight, then lower
// slot); the final transfer has last set and carries the pool size. csr_bus writes the
// block size and is always ready.
// sequence: a start runs per slot a selection scan, a divide, a bound scan and an
// n-squared gap search (the single table read port is visited by read and execute
// steps), then a multiply. req_bus is not ready while a run is in progress.
// reset clears the loaded and placed sets and the result valid flag and sets block
// size to 1; the slot tables need no clearing. when the receiver stalls the block
// holds the pending result and waits; nothing is dropped.
module aliased_memory_best_fit_placer (
   input  logic           clock,
   input  logic           reset,
   amp_req_if.sink        req_bus,
   amp_rsp_if.source      rsp_bus,
   amp_csr_if.sink        csr_bus
);

   amp_pkg::state_type                state_ff, state_in;
   logic [amp_pkg::BLK_W-1:0]         blk_ff;
   logic [amp_pkg::BLK_W-1:0]         blk_eff;
   logic [amp_pkg::MAX_RES-1:0]       loaded_ff;
   logic [amp_pkg::MAX_RES-1:0]       placed_ff;
   logic [amp_pkg::SLOT_W-1:0]        addr_ff;
   logic [amp_pkg::SLOT_W-1:0]        k_ff;
   logic [amp_pkg::SLOT_W-1:0]        cur_ff;
   logic [amp_pkg::MAX_RES-1:0]       cur_row_ff;
   logic [amp_pkg::POS_W-1:0]         req_ff;
   logic                              sel_found_ff;
   logic [amp_pkg::SLOT_W-1:0]        sel_id_ff;
   logic [amp_pkg::SIZE_W-1:0]        sel_size_ff;
   logic [amp_pkg::WT_W-1:0]          sel_wt_ff;
   logic                              any_ff;
   logic [amp_pkg::POS_W-1:0]         minbg_ff;
   logic [amp_pkg::POS_W-1:0]         maxend_ff;
   logic [amp_pkg::POS_W-1:0]         p_ff;
   logic                              cov_ff;
   logic                              nbf_ff;
   logic [amp_pkg::POS_W-1:0]         nb_ff;
   logic [amp_pkg::POS_W-1:0]         best_pos_ff;
   logic [amp_pkg::POS_W-1:0]         best_size_ff;
   logic                              best_inf_ff;
   logic [amp_pkg::POS_W-1:0]         pool_ff;
   logic                              have_pend_ff;
   logic [amp_pkg::SLOT_W-1:0]        pend_id_ff;
   logic [amp_pkg::BYTE_W-1:0]        pend_off_ff;
   logic [amp_pkg::BYTE_W-1:0]        pool_bytes_ff;
   logic                              rsp_valid_ff;
   logic [amp_pkg::SLOT_W-1:0]        rsp_id_ff;
   logic [amp_pkg::BYTE_W-1:0]        rsp_off_ff;
   logic [amp_pkg::BYTE_W-1:0]        rsp_pool_ff;
   logic                              rsp_last_ff;

   logic [amp_pkg::SIZE_W-1:0]        rd_size;
   logic [amp_pkg::WT_W-1:0]          rd_wt;
   logic [amp_pkg::MAX_RES-1:0]       rd_row;
   logic [amp_pkg::POS_W-1:0]         rd_begin;
   logic [amp_pkg::POS_W-1:0]         rd_end;

   amp_pkg::md_ctrl_type              md_ctrl;
   amp_pkg::md_stat_type              md_stat;
   logic [amp_pkg::POS_W-1:0]         md_a;
   logic [amp_pkg::POS_W-1:0]         md_quo;
   logic                              md_rem_nz;
   logic [amp_pkg::PROD_W-1:0]        md_prod;
   logic [amp_pkg::BYTE_W-1:0]        prod_sat;

   logic                              req_acc;
   logic                              ld_we;
   logic                              pl_we;
   logic                              out_free;
   logic                              rsp_load;
   logic                              at_last;
   logic                              k_last;
   logic                              sel_cand;
   logic                              sel_better;
   logic                              sel_take;
   logic                              sel_any;
   logic                              elig;
   logic                              any_n;
   logic [amp_pkg::POS_W-1:0]         minbg_n;
   logic [amp_pkg::POS_W-1:0]         maxend_n;
   logic                              cov_n;
   logic                              nbf_n;
   logic [amp_pkg::POS_W-1:0]         nb_n;
   logic [amp_pkg::POS_W-1:0]         gap;
   logic                              gap_wins;
   logic [amp_pkg::POS_W-1:0]         end_pos;

   assign blk_eff  = (blk_ff == '0) ? amp_pkg::BLK_W'(1) : blk_ff;
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign ld_we    = req_acc && (req_bus.op == amp_pkg::OP_LOAD) &&
                     ({1'b0, req_bus.resource_id} < amp_pkg::SLOT_CNT);
   assign pl_we    = state_ff == amp_pkg::ST_FIN;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load = out_free &&
                     (state_ff == amp_pkg::ST_EMIT || state_ff == amp_pkg::ST_LASTOUT);
   assign at_last  = addr_ff == amp_pkg::LAST_SLOT;
   assign k_last   = k_ff == amp_pkg::LAST_SLOT;
   assign end_pos  = best_pos_ff + req_ff;
   assign prod_sat = (md_prod[amp_pkg::PROD_W-1:amp_pkg::BYTE_W] != '0) ? amp_pkg::BYTE_MAX
                     : md_prod[amp_pkg::BYTE_W-1:0];

   // sort order: larger size, then higher weight; ascending scan keeps the lower slot
   assign sel_cand   = loaded_ff[addr_ff] && !placed_ff[addr_ff];
   assign sel_better = (rd_size > sel_size_ff) ||
                       (rd_size == sel_size_ff && rd_wt > sel_wt_ff);
   assign sel_take   = sel_cand && (!sel_found_ff || sel_better);
   assign sel_any    = sel_found_ff || sel_take;

   // conflicting, placed, non-empty interval at addr_ff
   assign elig = placed_ff[addr_ff] && (rd_end > rd_begin) &&
                 (cur_row_ff[addr_ff] || rd_row[cur_ff]);

   always_comb begin
      any_n    = any_ff;
      minbg_n  = minbg_ff;
      maxend_n = maxend_ff;
      if (elig) begin
         any_n = 1'b1;
         if (!any_ff || rd_begin < minbg_ff) begin
            minbg_n = rd_begin;
         end
         if (rd_end > maxend_ff) begin
            maxend_n = rd_end;
         end
      end
   end

   always_comb begin
      cov_n = cov_ff;
      nbf_n = nbf_ff;
      nb_n  = nb_ff;
      if (elig) begin
         if (rd_begin <= p_ff && p_ff < rd_end) begin
            cov_n = 1'b1;
         end
         if (rd_begin > p_ff && (!nbf_ff || rd_begin < nb_ff)) begin
            nbf_n = 1'b1;
            nb_n  = rd_begin;
         end
      end
      gap      = nb_n - p_ff;
      gap_wins = !cov_n && nbf_n && (req_ff <= gap) &&
                 (best_inf_ff || gap < best_size_ff ||
                  (gap == best_size_ff && p_ff < best_pos_ff));
   end

   always_comb begin
      state_in       = state_ff;
      md_ctrl.start  = 1'b0;
      md_ctrl.is_mul = 1'b0;
      md_a           = {{(amp_pkg::POS_W - amp_pkg::SIZE_W){1'b0}}, rd_size};
      case (state_ff)
         amp_pkg::ST_IDLE: begin
            if (req_acc && req_bus.op == amp_pkg::OP_START && loaded_ff != '0) begin
               state_in = amp_pkg::ST_SEL_RD;
            end
         end
         amp_pkg::ST_SEL_RD: state_in = amp_pkg::ST_SEL_EX;
         amp_pkg::ST_SEL_EX: begin
            if (!at_last) begin
               state_in = amp_pkg::ST_SEL_RD;
            end else if (sel_any) begin
               state_in = have_pend_ff ? amp_pkg::ST_EMIT : amp_pkg::ST_CUR_RD;
            end else begin
               state_in = have_pend_ff ? amp_pkg::ST_POOL : amp_pkg::ST_IDLE;
            end
         end
         amp_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = amp_pkg::ST_CUR_RD;
            end
         end
         amp_pkg::ST_CUR_RD: state_in = amp_pkg::ST_CUR_EX;
         amp_pkg::ST_CUR_EX: begin
            md_ctrl.start = 1'b1;
            state_in      = amp_pkg::ST_DIVW;
         end
         amp_pkg::ST_DIVW: begin
            if (md_stat.done) begin
               state_in = amp_pkg::ST_A_RD;
            end
         end
         amp_pkg::ST_A_RD: state_in = amp_pkg::ST_A_EX;
         amp_pkg::ST_A_EX: begin
            if (at_last) begin
               state_in = any_n ? amp_pkg::ST_K_RD : amp_pkg::ST_FIN;
            end else begin
               state_in = amp_pkg::ST_A_RD;
            end
         end
         amp_pkg::ST_K_RD: state_in = amp_pkg::ST_K_EX;
         amp_pkg::ST_K_EX: begin
            if (elig) begin
               state_in = amp_pkg::ST_J_RD;
            end else begin
               state_in = k_last ? amp_pkg::ST_FIN : amp_pkg::ST_K_RD;
            end
         end
         amp_pkg::ST_J_RD: state_in = amp_pkg::ST_J_EX;
         amp_pkg::ST_J_EX: begin
            if (!at_last) begin
               state_in = amp_pkg::ST_J_RD;
            end else begin
               state_in = k_last ? amp_pkg::ST_FIN : amp_pkg::ST_K_RD;
            end
         end
         amp_pkg::ST_FIN: begin
            md_ctrl.start  = 1'b1;
            md_ctrl.is_mul = 1'b1;
            md_a           = best_pos_ff;
            state_in       = amp_pkg::ST_MULW;
         end
         amp_pkg::ST_MULW: begin
            if (md_stat.done) begin
               state_in = amp_pkg::ST_SEL_RD;
            end
         end
         amp_pkg::ST_POOL: begin
            md_ctrl.start  = 1'b1;
            md_ctrl.is_mul = 1'b1;
            md_a           = pool_ff;
            state_in       = amp_pkg::ST_POOLW;
         end
         amp_pkg::ST_POOLW: begin
            if (md_stat.done) begin
               state_in = amp_pkg::ST_LASTOUT;
            end
         end
         amp_pkg::ST_LASTOUT: begin
            if (out_free) begin
               state_in = amp_pkg::ST_IDLE;
            end
         end
         default: state_in = amp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff       <= amp_pkg::BLK_W'(1);
         loaded_ff    <= '0;
         placed_ff    <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            blk_ff <= csr_bus.data;
         end
         if (ld_we) begin
            loaded_ff[req_bus.resource_id] <= 1'b1;
         end
         if (req_acc && req_bus.op == amp_pkg::OP_START) begin
            placed_ff    <= '0;
            have_pend_ff <= 1'b0;
         end
         if (pl_we) begin
            placed_ff[cur_ff] <= 1'b1;
         end
         if (state_ff == amp_pkg::ST_MULW && md_stat.done) begin
            have_pend_ff <= 1'b1;
         end
         if (rsp_load) begin
            have_pend_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // placement datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         amp_pkg::ST_IDLE: begin
            pool_ff      <= '0;
            addr_ff      <= '0;
            sel_found_ff <= 1'b0;
         end
         amp_pkg::ST_SEL_EX: begin
            if (sel_take) begin
               sel_found_ff <= 1'b1;
               sel_id_ff    <= addr_ff;
               sel_size_ff  <= rd_size;
               sel_wt_ff    <= rd_wt;
            end
            addr_ff <= addr_ff + 1'b1;
            if (at_last) begin
               cur_ff  <= sel_take ? addr_ff : sel_id_ff;
               addr_ff <= sel_take ? addr_ff : sel_id_ff;
            end
         end
         amp_pkg::ST_CUR_EX: cur_row_ff <= rd_row;
         amp_pkg::ST_DIVW: begin
            req_ff    <= md_quo + amp_pkg::POS_W'(md_rem_nz);
            addr_ff   <= '0;
            any_ff    <= 1'b0;
            maxend_ff <= '0;
         end
         amp_pkg::ST_A_EX: begin
            any_ff    <= any_n;
            minbg_ff  <= minbg_n;
            maxend_ff <= maxend_n;
            addr_ff   <= addr_ff + 1'b1;
            if (at_last) begin
               k_ff         <= '0;
               addr_ff      <= '0;
               best_size_ff <= minbg_n;
               // leading gap below the lowest interval, else after the last one
               if (any_n && minbg_n >= req_ff) begin
                  best_inf_ff <= 1'b0;
                  best_pos_ff <= '0;
               end else begin
                  best_inf_ff <= 1'b1;
                  best_pos_ff <= maxend_n;
               end
            end
         end
         amp_pkg::ST_K_EX: begin
            if (elig) begin
               p_ff    <= rd_end;
               cov_ff  <= 1'b0;
               nbf_ff  <= 1'b0;
               addr_ff <= '0;
            end else begin
               k_ff    <= k_ff + 1'b1;
               addr_ff <= k_ff + 1'b1;
            end
         end
         amp_pkg::ST_J_EX: begin
            cov_ff  <= cov_n;
            nbf_ff  <= nbf_n;
            nb_ff   <= nb_n;
            addr_ff <= addr_ff + 1'b1;
            if (at_last) begin
               if (gap_wins) begin
                  best_inf_ff  <= 1'b0;
                  best_size_ff <= gap;
                  best_pos_ff  <= p_ff;
               end
               k_ff    <= k_ff + 1'b1;
               addr_ff <= k_ff + 1'b1;
            end
         end
         amp_pkg::ST_FIN: begin
            pend_id_ff <= cur_ff;
            if (end_pos > pool_ff) begin
               pool_ff <= end_pos;
            end
         end
         amp_pkg::ST_MULW: begin
            if (md_stat.done) begin
               pend_off_ff  <= prod_sat;
               addr_ff      <= '0;
               sel_found_ff <= 1'b0;
            end
         end
         amp_pkg::ST_POOLW: begin
            if (md_stat.done) begin
               pool_bytes_ff <= prod_sat;
            end
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_id_ff   <= pend_id_ff;
         rsp_off_ff  <= pend_off_ff;
         rsp_last_ff <= state_ff == amp_pkg::ST_LASTOUT;
         rsp_pool_ff <= (state_ff == amp_pkg::ST_LASTOUT) ? pool_bytes_ff : '0;
      end
   end

   amp_store u_store (
      .clock    (clock),
      .ld_we    (ld_we),
      .ld_addr  (req_bus.resource_id),
      .ld_size  (req_bus.size_bytes),
      .ld_wt    (req_bus.rank_weight),
      .ld_row   (req_bus.conflict_mask),
      .pl_we    (pl_we),
      .pl_addr  (cur_ff),
      .pl_begin (best_pos_ff),
      .pl_end   (end_pos),
      .rd_addr  (addr_ff),
      .rd_size  (rd_size),
      .rd_wt    (rd_wt),
      .rd_row   (rd_row),
      .rd_begin (rd_begin),
      .rd_end   (rd_end)
   );

   amp_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (md_ctrl),
      .a      (md_a),
      .b      (blk_eff),
      .stat   (md_stat),
      .quo    (md_quo),
      .rem_nz (md_rem_nz),
      .prod   (md_prod)
   );

   assign req_bus.ready        = state_ff == amp_pkg::ST_IDLE;
   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.placed_id    = rsp_id_ff;
   assign rsp_bus.offset_bytes = rsp_off_ff;
   assign rsp_bus.pool_bytes   = rsp_pool_ff;
   assign rsp_bus.last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_placed_loaded: assert property (@(posedge clock) disable iff (reset)
      (placed_ff & ~loaded_ff) == '0)
      else $error("placed slot that was never loaded");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result register overwritten while stalled");

   a_md_idle_start: assert property (@(posedge clock) disable iff (reset)
      md_ctrl.start |-> !md_stat.busy)
      else $error("shared unit started while busy");
`endif

endmodule

FILE: rtl/core/amp_store.sv
// slot tables: sizes, weights, conflict rows and placed intervals
module amp_store (
   input  logic                            clock,
   input  logic                            ld_we,
   input  logic [amp_pkg::SLOT_W-1:0]      ld_addr,
   input  logic [amp_pkg::SIZE_W-1:0]      ld_size,
   input  logic [amp_pkg::WT_W-1:0]        ld_wt,
   input  logic [amp_pkg::MAX_RES-1:0]     ld_row,
   input  logic                            pl_we,
   input  logic [amp_pkg::SLOT_W-1:0]      pl_addr,
   input  logic [amp_pkg::POS_W-1:0]       pl_begin,
   input  logic [amp_pkg::POS_W-1:0]       pl_end,
   input  logic [amp_pkg::SLOT_W-1:0]      rd_addr,
   output logic [amp_pkg::SIZE_W-1:0]      rd_size,
   output logic [amp_pkg::WT_W-1:0]        rd_wt,
   output logic [amp_pkg::MAX_RES-1:0]     rd_row,
   output logic [amp_pkg::POS_W-1:0]       rd_begin,
   output logic [amp_pkg::POS_W-1:0]       rd_end
);

   logic [amp_pkg::SIZE_W-1:0]  size_mem  [amp_pkg::MAX_RES];
   logic [amp_pkg::WT_W-1:0]    wt_mem    [amp_pkg::MAX_RES];
   logic [amp_pkg::MAX_RES-1:0] row_mem   [amp_pkg::MAX_RES];
   logic [amp_pkg::POS_W-1:0]   begin_mem [amp_pkg::MAX_RES];
   logic [amp_pkg::POS_W-1:0]   end_mem   [amp_pkg::MAX_RES];

   always_ff @(posedge clock) begin
      if (ld_we) begin
         size_mem[ld_addr] <= ld_size;
         wt_mem[ld_addr]   <= ld_wt;
         row_mem[ld_addr]  <= ld_row;
      end
      if (pl_we) begin
         begin_mem[pl_addr] <= pl_begin;
         end_mem[pl_addr]   <= pl_end;
      end
      rd_size  <= size_mem[rd_addr];
      rd_wt    <= wt_mem[rd_addr];
      rd_row   <= row_mem[rd_addr];
      rd_begin <= begin_mem[rd_addr];
      rd_end   <= end_mem[rd_addr];
   end

endmodule

FILE: rtl/core/amp_muldiv.sv
// shared iterative unit: restoring divide for block rounding, shift-add multiply for bytes
module amp_muldiv (
   input  logic                            clock,
   input  logic                            reset,
   input  amp_pkg::md_ctrl_type            ctrl,
   input  logic [amp_pkg::POS_W-1:0]       a,
   input  logic [amp_pkg::BLK_W-1:0]       b,
   output amp_pkg::md_stat_type            stat,
   output logic [amp_pkg::POS_W-1:0]       quo,
   output logic                            rem_nz,
   output logic [amp_pkg::PROD_W-1:0]      prod
);

   logic                          busy_ff;
   logic                          done_ff;
   logic                          mul_ff;
   logic [amp_pkg::STEP_W-1:0]    cnt_ff;
   logic [amp_pkg::POS_W-1:0]     quo_ff;
   logic [amp_pkg::BLK_W-1:0]     rem_ff;
   logic [amp_pkg::BLK_W-1:0]     div_ff;
   logic [amp_pkg::PROD_W-1:0]    acc_ff;
   logic [amp_pkg::PROD_W-1:0]    mc_ff;
   logic [amp_pkg::BLK_W-1:0]     mp_ff;
   logic [amp_pkg::BLK_W:0]       trial;
   logic                          fits;
   logic [amp_pkg::STEP_W-1:0]    last_step;

   assign trial     = {rem_ff, quo_ff[amp_pkg::POS_W-1]};
   assign fits      = trial >= {1'b0, div_ff};
   assign last_step = mul_ff ? amp_pkg::STEP_W'(amp_pkg::BLK_W - 1)
                             : amp_pkg::STEP_W'(amp_pkg::POS_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            mul_ff  <= ctrl.is_mul;
            cnt_ff  <= '0;
            quo_ff  <= a;
            rem_ff  <= '0;
            div_ff  <= b;
            acc_ff  <= '0;
            mc_ff   <= amp_pkg::PROD_W'(a);
            mp_ff   <= b;
         end else if (busy_ff) begin
            if (mul_ff) begin
               if (mp_ff[0]) begin
                  acc_ff <= acc_ff + mc_ff;
               end
               mc_ff <= mc_ff << 1;
               mp_ff <= mp_ff >> 1;
            end else begin
               rem_ff <= fits ? amp_pkg::BLK_W'(trial - {1'b0, div_ff})
                              : amp_pkg::BLK_W'(trial);
               quo_ff <= {quo_ff[amp_pkg::POS_W-2:0], fits};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;
   assign rem_nz    = rem_ff != '0;
   assign prod      = acc_ff;

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the aliased memory best-fit placer
module tb_top;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SETTLE_CYCLES  = 400;

   typedef struct {
      logic                       op;
      logic [amp_pkg::SLOT_W-1:0] id;
      logic [amp_pkg::SIZE_W-1:0] size;
      logic [amp_pkg::WT_W-1:0]   weight;
      logic [63:0]                mask;
   } load_item_type;

   typedef struct {
      logic [amp_pkg::SLOT_W-1:0] id;
      logic [amp_pkg::BYTE_W-1:0] offset;
      logic [amp_pkg::BYTE_W-1:0] pool;
      logic                       last;
   } placement_type;

   class scoreboard_type;
      logic [amp_pkg::BLK_W-1:0]  block_size;
      logic [63:0]                loaded;
      logic [amp_pkg::SIZE_W-1:0] sizes [amp_pkg::MAX_RES];
      logic [amp_pkg::WT_W-1:0]   weights [amp_pkg::MAX_RES];
      logic [63:0]                rows [amp_pkg::MAX_RES];
      logic [63:0]                begins [amp_pkg::MAX_RES];
      logic [63:0]                ends [amp_pkg::MAX_RES];
      logic [63:0]                placed;
      placement_type              pending [$];
      int                         errors;

      function new();
         block_size = 1;
         loaded = '0;
         placed = '0;
         errors = 0;
      endfunction

      function logic [63:0] eff_block();
         return (block_size == 0) ? 64'd1 : 64'(block_size);
      endfunction

      function logic [amp_pkg::BYTE_W-1:0] blocks_to_bytes(logic [63:0] blocks);
         logic [63:0] v;
         v = blocks * eff_block();
         return (v > 64'(amp_pkg::BYTE_MAX)) ? amp_pkg::BYTE_MAX : v[amp_pkg::BYTE_W-1:0];
      endfunction

      function bit ahead_of(int a, int b);
         if (sizes[a] != sizes[b]) return sizes[a] > sizes[b];
         if (weights[a] != weights[b]) return weights[a] > weights[b];
         return a < b;
      endfunction

      function bit overlaps_forbidden(int a, int b);
         return rows[a][b] || rows[b][a];
      endfunction

      function logic [63:0] best_fit(int cur, logic [63:0] need);
         logic [63:0] bg [amp_pkg::MAX_RES];
         logic [63:0] en [amp_pkg::MAX_RES];
         logic [63:0] best_pos, best_len, run_end, gap;
         int n, i;
         n = 0;
         for (int j = 0; j < amp_pkg::MAX_RES; j++) begin
            if (!placed[j] || ends[j] <= begins[j] || !overlaps_forbidden(cur, j)) continue;
            i = n;
            while (i > 0 && bg[i-1] > begins[j]) begin
               bg[i] = bg[i-1];
               en[i] = en[i-1];
               i--;
            end
            bg[i] = begins[j];
            en[i] = ends[j];
            n++;
         end
         if (n == 0) return 0;
         run_end = 0;
         for (i = 0; i < n; i++) if (en[i] > run_end) run_end = en[i];
         if (bg[0] >= need) begin
            best_pos = 0;
            best_len = bg[0];
         end else begin
            best_pos = run_end;
            best_len = '1;
         end
         run_end = en[0];
         for (i = 1; i < n; i++) begin
            if (bg[i] > run_end) begin
               gap = bg[i] - run_end;
               if (need <= gap && gap < best_len) begin
                  best_len = gap;
                  best_pos = run_end;
               end
            end
            if (en[i] > run_end) run_end = en[i];
         end
         return best_pos;
      endfunction

      function void note_request(load_item_type it);
         int order [amp_pkg::MAX_RES];
         int n, k, id;
         logic [63:0] blk, need, pos, pool_blk;
         placement_type r;
         if (it.op == amp_pkg::OP_LOAD) begin
            sizes[it.id] = it.size;
            weights[it.id] = it.weight;
            rows[it.id] = it.mask;
            loaded[it.id] = 1'b1;
            return;
         end
         placed = '0;
         pool_blk = 0;
         blk = eff_block();
         n = 0;
         for (int i = 0; i < amp_pkg::MAX_RES; i++) begin
            if (!loaded[i]) continue;
            k = n;
            while (k > 0 && ahead_of(i, order[k-1])) begin
               order[k] = order[k-1];
               k--;
            end
            order[k] = i;
            n++;
         end
         for (int i = 0; i < n; i++) begin
            id = order[i];
            need = 64'(sizes[id]) / blk + ((64'(sizes[id]) % blk) != 0 ? 64'd1 : 64'd0);
            pos = best_fit(id, need);
            begins[id] = pos;
            ends[id] = pos + need;
            placed[id] = 1'b1;
            if (pos + need > pool_blk) pool_blk = pos + need;
            r.id = amp_pkg::SLOT_W'(id);
            r.offset = blocks_to_bytes(pos);
            r.pool = '0;
            r.last = 1'b0;
            if (i == n - 1) begin
               r.pool = blocks_to_bytes(pool_blk);
               r.last = 1'b1;
            end
            pending = {pending, r};
         end
      endfunction

      function void check_placement(placement_type got);
         placement_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result id=%0d offset=%0h", $time, got.id, got.offset);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.id !== exp.id) begin
            $display("%0t: placed_id expected %0d actual %0d", $time, exp.id, got.id);
            errors++;
         end
         if (got.offset !== exp.offset) begin
            $display("%0t: offset_bytes expected %0h actual %0h", $time, exp.offset, got.offset);
            errors++;
         end
         if (got.pool !== exp.pool) begin
            $display("%0t: pool_bytes expected %0h actual %0h", $time, exp.pool, got.pool);
            errors++;
         end
         if (got.last !== exp.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   int   idle_count;
   scoreboard_type sb;

   amp_req_if req_bus ();
   amp_rsp_if rsp_bus ();
   amp_csr_if csr_bus ();

   aliased_memory_best_fit_placer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // slots used by the stimulus; together they toggle every id bit
   logic [amp_pkg::SLOT_W-1:0] slot_pool [8] =
      '{6'd0, 6'd63, 6'd21, 6'd42, 6'd5, 6'd58, 6'd17, 6'd46};

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial sb = new();

   // transfer monitors
   always @(posedge clock) begin
      load_item_type it;
      placement_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            it.op = req_bus.op;
            it.id = req_bus.resource_id;
            it.size = req_bus.size_bytes;
            it.weight = req_bus.rank_weight;
            it.mask = req_bus.conflict_mask;
            sb.note_request(it);
         end
         if (csr_bus.valid && csr_bus.ready) sb.block_size = csr_bus.data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.id = rsp_bus.placed_id;
            got.offset = rsp_bus.offset_bytes;
            got.pool = rsp_bus.pool_bytes;
            got.last = rsp_bus.last;
            sb.check_placement(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // result-side backpressure
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!quiet) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   task automatic send_request(load_item_type it);
      req_bus.op <= it.op;
      req_bus.resource_id <= it.id;
      req_bus.size_bytes <= it.size;
      req_bus.rank_weight <= it.weight;
      req_bus.conflict_mask <= it.mask;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_size(logic [amp_pkg::BLK_W-1:0] value);
      drain_results();
      csr_bus.data <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic load_item_type make_load(logic [amp_pkg::SLOT_W-1:0] id,
                                               logic [amp_pkg::SIZE_W-1:0] size,
                                               logic [amp_pkg::WT_W-1:0] weight,
                                               logic [63:0] mask);
      load_item_type it;
      it.op = amp_pkg::OP_LOAD;
      it.id = id;
      it.size = size;
      it.weight = weight;
      it.mask = mask;
      return it;
   endfunction

   function automatic load_item_type make_start();
      load_item_type it;
      it = make_load('0, '0, '0, '0);
      it.op = amp_pkg::OP_START;
      it.id = amp_pkg::SLOT_W'($urandom);
      it.size = amp_pkg::SIZE_W'({$urandom, $urandom});
      it.weight = amp_pkg::WT_W'($urandom);
      it.mask = {$urandom, $urandom};
      return it;
   endfunction

   function automatic load_item_type random_load();
      logic [amp_pkg::SIZE_W-1:0] size;
      logic [amp_pkg::WT_W-1:0]   weight;
      logic [63:0]                mask;
      case ($urandom_range(0, 5))
         0: size = '0;
         1: size = '1;
         2: size = amp_pkg::SIZE_W'({$urandom, $urandom});
         3: size = amp_pkg::SIZE_W'($urandom_range(1, 4)) * 4096;
         default: size = amp_pkg::SIZE_W'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 3))
         0: weight = '0;
         1: weight = '1;
         default: weight = amp_pkg::WT_W'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 4))
         0: mask = '0;
         1: mask = '1;
         2: mask = {$urandom, $urandom};
         default: begin
            mask = '0;
            foreach (slot_pool[k]) if ($urandom_range(0, 1)) mask[slot_pool[k]] = 1'b1;
         end
      endcase
      return make_load(slot_pool[$urandom_range(0, 7)], size, weight, mask);
   endfunction

   initial begin
      logic [amp_pkg::BLK_W-1:0] blk_values [6] =
         '{17'd0, 17'd65536, 17'd1, 17'd65535, 17'd3, 17'd4096};
      quiet = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.op <= amp_pkg::OP_LOAD;
      req_bus.resource_id <= '0;
      req_bus.size_bytes <= '0;
      req_bus.rank_weight <= '0;
      req_bus.conflict_mask <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start with an empty set gives no result
      send_request(make_start());
      write_block_size(17'd0);
      // zero-size slot, full-size slot, equal sizes split by weight, touching intervals
      send_request(make_load(6'd0, '0, '0, '1));
      send_request(make_load(6'd63, '1, '1, '1));
      send_request(make_load(6'd21, 40'd100, 16'd5, 64'h0000_0400_0000_0000));
      send_request(make_load(6'd42, 40'd100, 16'd9, 64'h0000_0000_0020_0000));
      send_request(make_load(6'd5, 40'd50, 16'd0, 64'h0000_0400_0020_0000));
      send_request(make_load(6'd58, 40'd30, 16'd0, 64'h0000_0000_0000_0020));
      send_request(make_start());
      // repeated start with the same set
      send_request(make_start());
      write_block_size(17'd65536);
      // overwrite a slot, then leading gap and interior gaps
      send_request(make_load(6'd63, 40'd200000, 16'd0, 64'h0000_4000_0002_0020));
      send_request(make_load(6'd17, 40'd70000, 16'd3, 64'h8000_0000_0000_0020));
      send_request(make_load(6'd46, 40'd1, 16'd3, 64'h8000_0000_0002_0000));
      send_request(make_start());
      write_block_size(17'd1);
      send_request(make_load(6'd63, '1, 16'd1, '1));
      send_request(make_start());

      for (int phase = 0; phase < 30; phase++) begin
         if (phase == 26) quiet = 1'b1;
         if (phase % 4 == 0) begin
            if (phase < 24) write_block_size(blk_values[phase / 4]);
            else write_block_size(amp_pkg::BLK_W'($urandom_range(1, 65536)));
         end
         repeat ($urandom_range(8, 14)) send_request(random_load());
         send_request(make_start());
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: aliased_memory_best_fit_placer.f
rtl/core/amp_pkg.sv
rtl/core/amp_if.sv
rtl/core/amp_store.sv
rtl/core/amp_muldiv.sv
rtl/core/aliased_memory_best_fit_placer.sv
dv/tb_top.sv
